/* hdl/a64enc_pkg.sv */
// a64enc_pkg: shared types and constants for the A64 instruction word encoder.
// Holds opcode enum, request entry struct, base encodings. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package a64enc_pkg;

    typedef enum logic [4:0] {
        OP_MOV_REG  = 5'd0,
        OP_MOV_IMM  = 5'd1,
        OP_LDR      = 5'd2,
        OP_STR      = 5'd3,
        OP_LDP_PRE  = 5'd4,
        OP_STP_PRE  = 5'd5,
        OP_LDP_POST = 5'd6,
        OP_STP_POST = 5'd7,
        OP_ALU_REG  = 5'd8,
        OP_ALU_IMM  = 5'd9,
        OP_CMP_REG  = 5'd10,
        OP_CMP_IMM  = 5'd11,
        OP_B        = 5'd12,
        OP_BL       = 5'd13,
        OP_B_COND   = 5'd14,
        OP_CBZ      = 5'd15,
        OP_CBNZ     = 5'd16,
        OP_BR       = 5'd17,
        OP_BLR      = 5'd18,
        OP_RET      = 5'd19
    } op_t;

    localparam logic [4:0] OP_LAST = OP_RET;

    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd1;
    localparam logic [2:0] ALU_AND = 3'd2;
    localparam logic [2:0] ALU_ORR = 3'd3;
    localparam logic [2:0] ALU_EOR = 3'd4;
    localparam logic [2:0] ALU_BIC = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_ALIGN     = 2'd2;
    localparam logic [1:0] ST_UNSUPPORT = 2'd3;

    localparam logic [31:0] ENC_MOV_REG   = 32'h2A0003E0;
    localparam logic [31:0] ENC_MOVZ      = 32'h52800000;
    localparam logic [31:0] ENC_MOVK      = 32'h72800000;
    localparam logic [31:0] ENC_LS_UIMM   = 32'h39000000;
    localparam logic [31:0] ENC_LS_SIMM   = 32'h38000000;
    localparam logic [31:0] ENC_PAIR_X    = 32'hA8000000;
    localparam logic [31:0] ENC_PAIR_W    = 32'h28000000;
    localparam logic [31:0] ENC_ADD_IMM   = 32'h11000000;
    localparam logic [31:0] ENC_SUB_IMM   = 32'h51000000;
    localparam logic [31:0] ENC_CMP_REG   = 32'h6B00001F;
    localparam logic [31:0] ENC_CMP_IMM   = 32'h7100001F;
    localparam logic [31:0] ENC_B_COND    = 32'h54000000;
    localparam logic [31:0] ENC_B         = 32'h14000000;
    localparam logic [31:0] ENC_BL        = 32'h94000000;
    localparam logic [31:0] ENC_CBZ       = 32'h34000000;
    localparam logic [31:0] ENC_CBNZ      = 32'h35000000;
    localparam logic [31:0] ENC_BR        = 32'hD61F0000;
    localparam logic [31:0] ENC_BLR       = 32'hD63F0000;
    localparam logic [31:0] ENC_RET       = 32'hD65F03C0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified request: up to four words plus the index of the final one
    typedef struct packed {
        logic [3:0][31:0] words;
        logic [1:0]       last_idx;
        logic [1:0]       status;
    } entry_t;

    function automatic logic [7:0] alu_top(input logic [2:0] kind);
        logic [7:0] t;
        case (kind)
            ALU_ADD: t = 8'h0B;
            ALU_SUB: t = 8'h4B;
            ALU_AND: t = 8'h0A;
            ALU_ORR: t = 8'h2A;
            ALU_EOR: t = 8'h4A;
            default: t = 8'h0A;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

/* hdl/a64enc_front.sv */
// a64enc_front: accepts a request and encodes it into a queue entry.
// Depends on a64enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a64enc_front (
    input  wire logic               push,
    input  wire logic               q_full,
    input  wire logic [4:0]         op,
    input  wire logic [2:0]         alu_kind,
    input  wire logic               wide,
    input  wire logic [4:0]         rd,
    input  wire logic [4:0]         rn,
    input  wire logic [4:0]         rm,
    input  wire logic [63:0]        immediate,
    input  wire logic [15:0]        offset,
    input  wire logic [3:0]         condition,
    output logic                    wr_en,
    output a64enc_pkg::entry_t      wr_entry
);
    import a64enc_pkg::*;

    logic        sh;
    logic [11:0] i12;
    logic        imm_bad;
    logic        pair_mis;
    logic [6:0]  pair_q;
    logic        pair_bad;
    logic        ls_scaled;
    logic        ls_unscaled;
    logic [11:0] ls_uimm;
    logic [31:0] ls_base;
    logic        pre;
    logic        ld;

    // add/sub immediate: shift by 12 when low bits are clear and value fits 24 bits
    assign sh      = (immediate[11:0] == 12'h0) && (immediate[63:24] == 40'h0);
    assign i12     = sh ? immediate[23:12] : immediate[11:0];
    assign imm_bad = (immediate[63:32] != 32'h0) || (!sh && (immediate[31:12] != 20'h0));

    assign pair_mis = wide ? (offset[2:0] != 3'b0) : (offset[1:0] != 2'b0);
    assign pair_q   = wide ? offset[9:3] : offset[8:2];
    assign pair_bad = wide ? (offset[15:9] != {7{offset[15]}})
                           : (offset[15:8] != {8{offset[15]}});

    assign ls_scaled   = !offset[15] && (wide ? (offset[2:0] == 3'b0)
                                              : (offset[1:0] == 2'b0 && !offset[14]));
    assign ls_unscaled = (offset[15:8] == {8{offset[15]}});
    assign ls_uimm     = wide ? offset[14:3] : offset[13:2];
    assign ls_base     = {1'b1, wide, 30'b0};

    assign pre = (op == OP_LDP_PRE) || (op == OP_STP_PRE);
    assign ld  = (op == OP_LDR) || (op == OP_LDP_PRE) || (op == OP_LDP_POST);

    assign wr_en = push && !q_full && (op <= OP_LAST);

    always_comb
    begin
        logic [15:0] chunk;
        logic [2:0]  n;
        logic        started;
        logic [2:0]  max_hw;
        wr_entry = '0;
        n        = 3'd0;
        started  = 1'b0;
        chunk    = 16'h0;
        max_hw   = wide ? 3'd4 : 3'd2;
        unique case (op)
            OP_MOV_REG:
                wr_entry.words[0] = ENC_MOV_REG | {wide, 31'b0} | {11'b0, rn, 16'b0}
                                    | {27'b0, rd};
            OP_MOV_IMM:
            begin
                // MOVZ on the first nonzero halfword, MOVK after; top halfword if all zero
                for (int hw = 0; hw < 4; hw++)
                begin
                    chunk = immediate[hw*16 +: 16];
                    if ((3'(hw) < max_hw)
                        && (chunk != 16'h0 || (!started && 3'(hw) == max_hw - 3'd1)))
                    begin
                        wr_entry.words[n[1:0]] = (started ? ENC_MOVK : ENC_MOVZ)
                            | {wide, 31'b0} | {9'b0, 2'(hw), 21'b0}
                            | {11'b0, chunk, 5'b0} | {27'b0, rd};
                        n       = n + 3'd1;
                        started = 1'b1;
                    end
                end
                wr_entry.last_idx = 2'(n - 3'd1);
            end
            OP_LDR, OP_STR:
            begin
                if (ls_scaled)
                    wr_entry.words[0] = ls_base | ENC_LS_UIMM | {9'b0, ld, 22'b0}
                                        | {10'b0, ls_uimm, 10'b0} | {22'b0, rn, 5'b0}
                                        | {27'b0, rd};
                else if (ls_unscaled)
                    wr_entry.words[0] = ls_base | ENC_LS_SIMM | {9'b0, ld, 22'b0}
                                        | {11'b0, offset[8:0], 12'b0} | {22'b0, rn, 5'b0}
                                        | {27'b0, rd};
                else
                    wr_entry.status = ST_RANGE;
            end
            OP_LDP_PRE, OP_STP_PRE, OP_LDP_POST, OP_STP_POST:
            begin
                if (pair_mis)
                    wr_entry.status = ST_ALIGN;
                else if (pair_bad)
                    wr_entry.status = ST_RANGE;
                else
                    wr_entry.words[0] = (wide ? ENC_PAIR_X : ENC_PAIR_W)
                        | {7'b0, pre, 1'b1, 23'b0} | {9'b0, ld, 22'b0}
                        | {10'b0, pair_q, 15'b0} | {17'b0, rm, 10'b0}
                        | {22'b0, rn, 5'b0} | {27'b0, rd};
            end
            OP_ALU_REG:
            begin
                if (alu_kind > ALU_BIC)
                    wr_entry.status = ST_UNSUPPORT;
                else
                    wr_entry.words[0] = {alu_top(alu_kind), 24'b0} | {wide, 31'b0}
                        | {10'b0, (alu_kind == ALU_BIC), 21'b0} | {11'b0, rm, 16'b0}
                        | {22'b0, rn, 5'b0} | {27'b0, rd};
            end
            OP_ALU_IMM:
            begin
                if (alu_kind > ALU_SUB)
                    wr_entry.status = ST_UNSUPPORT;
                else if (imm_bad)
                    wr_entry.status = ST_RANGE;
                else
                    wr_entry.words[0] = ((alu_kind == ALU_ADD) ? ENC_ADD_IMM : ENC_SUB_IMM)
                        | {wide, 31'b0} | {9'b0, sh, 22'b0} | {10'b0, i12, 10'b0}
                        | {22'b0, rn, 5'b0} | {27'b0, rd};
            end
            OP_CMP_REG:
                wr_entry.words[0] = ENC_CMP_REG | {wide, 31'b0} | {11'b0, rm, 16'b0}
                                    | {22'b0, rn, 5'b0};
            OP_CMP_IMM:
            begin
                if (imm_bad)
                    wr_entry.status = ST_RANGE;
                else
                    wr_entry.words[0] = ENC_CMP_IMM | {wide, 31'b0} | {9'b0, sh, 22'b0}
                        | {10'b0, i12, 10'b0} | {22'b0, rn, 5'b0};
            end
            OP_B:      wr_entry.words[0] = ENC_B;
            OP_BL:     wr_entry.words[0] = ENC_BL;
            OP_B_COND: wr_entry.words[0] = ENC_B_COND | {28'b0, condition};
            OP_CBZ:    wr_entry.words[0] = ENC_CBZ | {wide, 31'b0} | {27'b0, rd};
            OP_CBNZ:   wr_entry.words[0] = ENC_CBNZ | {wide, 31'b0} | {27'b0, rd};
            OP_BR:     wr_entry.words[0] = ENC_BR | {22'b0, rn, 5'b0};
            OP_BLR:    wr_entry.words[0] = ENC_BLR | {22'b0, rn, 5'b0};
            OP_RET:    wr_entry.words[0] = ENC_RET;
            default:   wr_entry = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/a64enc_queue.sv */
// a64enc_queue: short register FIFO of encoded requests between front and back.
// Depends on a64enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a64enc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire a64enc_pkg::entry_t wr_entry,
    input  wire logic               rd_en,
    output logic                    q_full,
    output logic                    q_empty,
    output a64enc_pkg::entry_t      head
);
    import a64enc_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

`default_nettype wire

/* hdl/a64enc_back.sv */
// a64enc_back: emits one word per cycle from the queue head while pop allows, places it
// in the buffer against capacity, keeps the sticky overflow flag. Depends on a64enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a64enc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               q_empty,
    input  wire a64enc_pkg::entry_t head,
    output logic                    rd_en,
    output logic                    empty,
    input  wire logic               pop,
    output logic [31:0]             instr_word,
    output logic [23:0]             byte_offset,
    output logic                    last,
    output logic [1:0]              status,
    output logic                    overflow
);
    import a64enc_pkg::*;

    logic [23:0] cap_reg;
    logic [23:0] wo_reg, wo_next;
    logic        ovf_reg, ovf_next;
    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [31:0] word_reg, word_next;
    logic [23:0] boff_reg, boff_next;
    logic        last_reg, last_next;
    logic [1:0]  st_reg, st_next;
    logic        oflag_reg, oflag_next;
    logic        load;
    logic        fits;
    logic        is_last;

    assign load    = !valid_reg || pop;
    assign fits    = ({1'b0, wo_reg} + 25'd4) <= {1'b0, cap_reg};
    assign is_last = (idx_reg == head.last_idx) || (head.status != ST_OK);
    assign rd_en   = load && !q_empty && is_last;

    always_comb
    begin
        wo_next    = wo_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        word_next  = word_reg;
        boff_next  = boff_reg;
        last_next  = last_reg;
        st_next    = st_reg;
        oflag_next = oflag_reg;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                boff_next = wo_reg;
                last_next = is_last;
                st_next   = head.status;
                idx_next  = is_last ? 2'd0 : idx_reg + 2'd1;
                if (head.status != ST_OK)
                begin
                    // error word: nothing placed
                    word_next  = '0;
                    oflag_next = ovf_reg;
                end
                else
                begin
                    word_next = head.words[idx_reg];
                    if (fits)
                        wo_next = wo_reg + 24'd4;
                    else
                        ovf_next = 1'b1;
                    oflag_next = ovf_reg || !fits;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= '0;
            wo_reg    <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                cap_reg <= cfg_data;
            wo_reg    <= wo_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        boff_reg  <= boff_next;
        last_reg  <= last_next;
        st_reg    <= st_next;
        oflag_reg <= oflag_next;
    end

    assign empty       = !valid_reg;
    assign instr_word  = word_reg;
    assign byte_offset = boff_reg;
    assign last        = last_reg;
    assign status      = st_reg;
    assign overflow    = oflag_reg;

endmodule

`default_nettype wire

/* hdl/a64_instruction_word_encoder_unit.sv */
// a64_instruction_word_encoder_unit: top level of the A64 instruction word encoder.
// Instantiates a64enc_front, a64enc_queue and a64enc_back; uses a64enc_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   request  | push / full            | op alu_kind wide rd rn rm immediate offset
//            |                        | condition
//   config   | cfg_valid / cfg_ready  | cfg_data (capacity in bytes)
//   result   | empty / pop            | instr_word byte_offset last status overflow
//
// A request is encoded in the cycle it is accepted and lands in a 4-entry queue.
// The back end sends one word per cycle from the queue head through an output
// register while pop allows, so a request gives 1 to 4 words on the result side.
// full rises only when the queue holds four encoded requests; cfg_ready is always high.
// Reset clears the write offset, overflow flag, capacity and the queue.
`timescale 1ns / 1ps
`default_nettype none

module a64_instruction_word_encoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [4:0]  op,
    input  wire logic [2:0]  alu_kind,
    input  wire logic        wide,
    input  wire logic [4:0]  rd,
    input  wire logic [4:0]  rn,
    input  wire logic [4:0]  rm,
    input  wire logic [63:0] immediate,
    input  wire logic [15:0] offset,
    input  wire logic [3:0]  condition,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      instr_word,
    output logic [23:0]      byte_offset,
    output logic             last,
    output logic [1:0]       status,
    output logic             overflow
);
    import a64enc_pkg::*;

    logic   wr_en;
    entry_t wr_entry;
    logic   q_full;
    logic   q_empty;
    logic   rd_en;
    entry_t head;

    assign full      = q_full;
    assign cfg_ready = 1'b1;

    a64enc_front u_front (
        .push      (push),
        .q_full    (q_full),
        .op        (op),
        .alu_kind  (alu_kind),
        .wide      (wide),
        .rd        (rd),
        .rn        (rn),
        .rm        (rm),
        .immediate (immediate),
        .offset    (offset),
        .condition (condition),
        .wr_en     (wr_en),
        .wr_entry  (wr_entry)
    );

    a64enc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .q_full   (q_full),
        .q_empty  (q_empty),
        .head     (head)
    );

    a64enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .q_empty     (q_empty),
        .head        (head),
        .rd_en       (rd_en),
        .empty       (empty),
        .pop         (pop),
        .instr_word  (instr_word),
        .byte_offset (byte_offset),
        .last        (last),
        .status      (status),
        .overflow    (overflow)
    );

endmodule

`default_nettype wire

/* hdl/a64enc_checker.sv */
// a64enc_checker: port-level assertions for the encoder top level, with bind.
// Depends only on the ports of a64_instruction_word_encoder_unit.
`timescale 1ns / 1ps
`default_nettype none

module a64enc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [31:0] instr_word,
    input  wire logic [23:0] byte_offset,
    input  wire logic        last,
    input  wire logic [1:0]  status,
    input  wire logic        overflow
);

    // overflow never clears once a word showed it
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && overflow) |=> (empty || overflow))
        else $error("overflow flag cleared");

    // words land on 4-byte boundaries
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (byte_offset[1:0] == 2'b00))
        else $error("unaligned byte offset");

    // an error result is a single zero word
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != 2'd0) |-> (instr_word == 32'h0 && last))
        else $error("error result carries a word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(instr_word) && $stable(byte_offset)))
        else $error("stalled result changed");

endmodule

bind a64_instruction_word_encoder_unit a64enc_checker u_chk (.*);

`default_nettype wire

/* tb/tb.sv */
// tb: self-checking bench for a64_instruction_word_encoder_unit.
// Drives encode requests through the push/full side and checks every word on the
// empty/pop side against an in-bench encoder model. Depends on a64enc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import a64enc_pkg::*;

    localparam logic [4:0]  OP_UNDEF_TOP    = 5'd31;
    localparam logic [2:0]  ALU_UNDEF_TOP   = 3'd7;
    localparam logic [1:0]  MODE_PRE_INDEX  = 2'b11;
    localparam logic [1:0]  MODE_POST_INDEX = 2'b01;
    localparam logic [1:0]  SIZE_X          = 2'b11;
    localparam logic [1:0]  SIZE_W          = 2'b10;
    localparam logic [23:0] CAP_MAX         = 24'hFF_FFFF;
    localparam logic [23:0] CAP_NONE        = 24'd0;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          IDLE_PCT        = 29;

    typedef struct {
        logic [4:0]  op;
        logic [2:0]  kind;
        logic        wide;
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic [4:0]  rm;
        logic [63:0] imm;
        logic [15:0] offs;
        logic [3:0]  cond;
    } enc_req_t;

    typedef struct {
        logic [31:0] word;
        logic [23:0] at;
        logic        last;
        logic [1:0]  status;
        logic        ovf;
    } enc_word_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        full;
    logic [4:0]  op         = '0;
    logic [2:0]  alu_kind   = '0;
    logic        wide       = 1'b0;
    logic [4:0]  rd         = '0;
    logic [4:0]  rn         = '0;
    logic [4:0]  rm         = '0;
    logic [63:0] immediate  = '0;
    logic [15:0] offset     = '0;
    logic [3:0]  condition  = '0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data   = '0;
    logic        empty;
    logic        pop        = 1'b0;
    logic [31:0] instr_word;
    logic [23:0] byte_offset;
    logic        last;
    logic [1:0]  status;
    logic        overflow;

    // encoder model state
    logic [23:0] model_capacity  = '0;
    logic [23:0] write_ptr       = '0;
    logic        overflow_sticky = 1'b0;

    enc_req_t  pending_requests[$];
    enc_word_t expected_words[$];

    logic no_idle    = 1'b0;
    logic hold_armed = 1'b0;
    logic recv_stall = 1'b0;

    int fail_count      = 0;
    int requests_sent   = 0;
    int words_checked   = 0;
    int error_words     = 0;
    int dropped_words   = 0;
    int capacity_writes = 0;

    a64_instruction_word_encoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .alu_kind    (alu_kind),
        .wide        (wide),
        .rd          (rd),
        .rn          (rn),
        .rm          (rm),
        .immediate   (immediate),
        .offset      (offset),
        .condition   (condition),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .empty       (empty),
        .pop         (pop),
        .instr_word  (instr_word),
        .byte_offset (byte_offset),
        .last        (last),
        .status      (status),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic place_word(input logic [31:0] w, input logic is_last);
        enc_word_t e;
        e.at = write_ptr;
        if ({8'd0, write_ptr} + 32'd4 > {8'd0, model_capacity})
        begin
            overflow_sticky = 1'b1;
            dropped_words++;
        end
        else
            write_ptr = write_ptr + 24'd4;
        e.word   = w;
        e.last   = is_last;
        e.status = ST_OK;
        e.ovf    = overflow_sticky;
        expected_words.push_back(e);
    endtask

    task automatic place_error(input logic [1:0] code);
        enc_word_t e;
        e.word   = '0;
        e.at     = write_ptr;
        e.last   = 1'b1;
        e.status = code;
        e.ovf    = overflow_sticky;
        expected_words.push_back(e);
        error_words++;
    endtask

    // 12-bit add/sub immediate, shifted by 12 when the low bits are clear
    function automatic logic [1:0] split_addsub_imm(input logic [63:0] v,
                                                    output logic [11:0] field,
                                                    output logic shifted);
        logic [63:0] f;
        field   = '0;
        shifted = 1'b0;
        f       = v;
        if (v > 64'hFFFF_FFFF)
            return ST_RANGE;
        if (v[11:0] == 12'd0 && v <= 64'hFF_FFFF)
        begin
            shifted = 1'b1;
            f       = v >> 12;
        end
        field = f[11:0];
        return (f >= 64'd4096) ? ST_RANGE : ST_OK;
    endfunction

    task automatic encode_request(input enc_req_t req);
        logic [31:0] w;
        logic [31:0] seq [4];
        int          n;
        int          soff;
        int          scale;
        int          q;
        int          max_hw;
        logic        started;
        logic [15:0] chunk;
        logic [11:0] i12;
        logic        sh;
        logic [1:0]  st;
        w       = '0;
        n       = 0;
        started = 1'b0;
        if (req.op > OP_LAST)
            return;
        soff  = $signed(req.offs);
        scale = req.wide ? 8 : 4;
        case (op_t'(req.op))
            OP_MOV_REG:
            begin
                w = ENC_MOV_REG;
                w[31] = req.wide;
                w[20:16] = req.rn;
                w[4:0] = req.rd;
            end
            OP_MOV_IMM:
            begin
                // MOVZ on first nonzero halfword, MOVK after; all-zero gives MOVZ at top
                max_hw = req.wide ? 4 : 2;
                for (int hw = 0; hw < max_hw; hw++)
                begin
                    chunk = req.imm[hw*16 +: 16];
                    if (chunk != 16'd0 || (!started && hw == max_hw - 1))
                    begin
                        w = started ? ENC_MOVK : ENC_MOVZ;
                        w[31] = req.wide;
                        w[22:21] = 2'(hw);
                        w[20:5] = chunk;
                        w[4:0] = req.rd;
                        seq[n] = w;
                        n++;
                        started = 1'b1;
                    end
                end
            end
            OP_LDR, OP_STR:
            begin
                if (soff >= 0 && soff % scale == 0 && soff / scale < 4096)
                begin
                    w = ENC_LS_UIMM;
                    w[21:10] = 12'(soff / scale);
                end
                else if (soff >= -256 && soff <= 255)
                begin
                    w = ENC_LS_SIMM;
                    w[20:12] = req.offs[8:0];
                end
                else
                begin
                    place_error(ST_RANGE);
                    return;
                end
                w[31:30] = req.wide ? SIZE_X : SIZE_W;
                w[22] = (req.op == OP_LDR);
                w[9:5] = req.rn;
                w[4:0] = req.rd;
            end
            OP_LDP_PRE, OP_STP_PRE, OP_LDP_POST, OP_STP_POST:
            begin
                if (req.wide ? (req.offs[2:0] != 3'd0) : (req.offs[1:0] != 2'd0))
                begin
                    place_error(ST_ALIGN);
                    return;
                end
                q = soff / scale;
                if (q < -64 || q > 63)
                begin
                    place_error(ST_RANGE);
                    return;
                end
                w = req.wide ? ENC_PAIR_X : ENC_PAIR_W;
                w[24:23] = (req.op == OP_LDP_PRE || req.op == OP_STP_PRE) ?
                           MODE_PRE_INDEX : MODE_POST_INDEX;
                w[22] = (req.op == OP_LDP_PRE || req.op == OP_LDP_POST);
                w[21:15] = 7'(q);
                w[14:10] = req.rm;
                w[9:5] = req.rn;
                w[4:0] = req.rd;
            end
            OP_ALU_REG:
            begin
                case (req.kind)
                    ALU_ADD: w[31:24] = 8'h0B;
                    ALU_SUB: w[31:24] = 8'h4B;
                    ALU_AND: w[31:24] = 8'h0A;
                    ALU_ORR: w[31:24] = 8'h2A;
                    ALU_EOR: w[31:24] = 8'h4A;
                    ALU_BIC:
                    begin
                        w[31:24] = 8'h0A;
                        w[21] = 1'b1;
                    end
                    default:
                    begin
                        place_error(ST_UNSUPPORT);
                        return;
                    end
                endcase
                w[31] = req.wide;
                w[20:16] = req.rm;
                w[9:5] = req.rn;
                w[4:0] = req.rd;
            end
            OP_ALU_IMM:
            begin
                if (req.kind > ALU_SUB)
                begin
                    place_error(ST_UNSUPPORT);
                    return;
                end
                st = split_addsub_imm(req.imm, i12, sh);
                if (st != ST_OK)
                begin
                    place_error(st);
                    return;
                end
                w = (req.kind == ALU_ADD) ? ENC_ADD_IMM : ENC_SUB_IMM;
                w[31] = req.wide;
                w[22] = sh;
                w[21:10] = i12;
                w[9:5] = req.rn;
                w[4:0] = req.rd;
            end
            OP_CMP_REG:
            begin
                w = ENC_CMP_REG;
                w[31] = req.wide;
                w[20:16] = req.rm;
                w[9:5] = req.rn;
            end
            OP_CMP_IMM:
            begin
                st = split_addsub_imm(req.imm, i12, sh);
                if (st != ST_OK)
                begin
                    place_error(st);
                    return;
                end
                w = ENC_CMP_IMM;
                w[31] = req.wide;
                w[22] = sh;
                w[21:10] = i12;
                w[9:5] = req.rn;
            end
            OP_B:      w = ENC_B;
            OP_BL:     w = ENC_BL;
            OP_B_COND:
            begin
                w = ENC_B_COND;
                w[3:0] = req.cond;
            end
            OP_CBZ, OP_CBNZ:
            begin
                w = (req.op == OP_CBZ) ? ENC_CBZ : ENC_CBNZ;
                w[31] = req.wide;
                w[4:0] = req.rd;
            end
            OP_BR, OP_BLR:
            begin
                w = (req.op == OP_BR) ? ENC_BR : ENC_BLR;
                w[9:5] = req.rn;
            end
            OP_RET:    w = ENC_RET;
            default:   return;
        endcase
        if (req.op != OP_MOV_IMM)
        begin
            seq[0] = w;
            n = 1;
        end
        for (int i = 0; i < n; i++)
            place_word(seq[i], i == n - 1);
    endtask

    function automatic enc_req_t make_req(input logic [4:0] code, input logic [2:0] kind,
                                          input logic is_wide, input logic [63:0] imm,
                                          input int offs);
        enc_req_t r;
        r.op   = code;
        r.kind = kind;
        r.wide = is_wide;
        r.rd   = 5'($urandom);
        r.rn   = 5'($urandom);
        r.rm   = 5'($urandom);
        r.imm  = imm;
        r.offs = 16'(offs);
        r.cond = 4'($urandom);
        return r;
    endfunction

    function automatic enc_req_t random_request();
        enc_req_t r;
        int       v;
        r = make_req(5'($urandom_range(OP_LAST)), 3'($urandom_range(ALU_BIC)),
                     1'($urandom), '0, 0);
        if ($urandom_range(24) == 0)
            r.op = 5'($urandom_range(OP_UNDEF_TOP, OP_LAST + 1));
        if ($urandom_range(9) == 0)
            r.kind = 3'($urandom_range(ALU_UNDEF_TOP, ALU_BIC + 1));
        case ($urandom_range(4))
            0: r.imm = {$urandom, $urandom};
            1:
            begin
                for (int hw = 0; hw < 4; hw++)
                    r.imm[hw*16 +: 16] = ($urandom_range(1) != 0) ? 16'($urandom) : 16'h0;
            end
            2: r.imm = 64'($urandom_range(4095));
            3: r.imm = 64'($urandom_range(4095)) << 12;
            default: r.imm = 64'($urandom);
        endcase
        case ($urandom_range(3))
            0: v = int'($urandom_range(65535)) - 32768;
            1: v = int'($urandom_range(511)) - 256;
            2: v = int'($urandom_range(4095)) * (r.wide ? 8 : 4);
            default: v = (int'($urandom_range(135)) - 68) * (r.wide ? 8 : 4);
        endcase
        r.offs = 16'(v);
        return r;
    endfunction

    // undefined ops come on top of the requested count
    task automatic queue_random(input int count);
        enc_req_t r;
        int       n;
        n = 0;
        while (n < count)
        begin
            r = random_request();
            pending_requests.push_back(r);
            if (r.op <= OP_LAST)
                n++;
        end
    endtask

    task automatic write_capacity(input logic [23:0] bytes);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= bytes;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_capacity = bytes;
        capacity_writes++;
    endtask

    task automatic wait_until_drained();
        do @(negedge clk); while (pending_requests.size() != 0 || expected_words.size() != 0);
        // a trailing undefined op gives no word but may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : request_driver
        logic offer;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                encode_request(pending_requests.pop_front());
                requests_sent++;
            end
            offer = pending_requests.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT);
            if (offer)
            begin
                op        <= pending_requests[0].op;
                alu_kind  <= pending_requests[0].kind;
                wide      <= pending_requests[0].wide;
                rd        <= pending_requests[0].rd;
                rn        <= pending_requests[0].rn;
                rm        <= pending_requests[0].rm;
                immediate <= pending_requests[0].imm;
                offset    <= pending_requests[0].offs;
                condition <= pending_requests[0].cond;
            end
            push <= offer;
        end
    end

    always @(posedge clk)
    begin : word_monitor
        enc_word_t exp_w;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected word %h at %h", $time, instr_word,
                                 byte_offset);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    words_checked++;
                    if (instr_word !== exp_w.word || byte_offset !== exp_w.at ||
                        last !== exp_w.last || status !== exp_w.status ||
                        overflow !== exp_w.ovf)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch got %h @%h last %b st %0d ovf %b,",
                                     $time, instr_word, byte_offset, last, status, overflow,
                                     " expected %h @%h last %b st %0d ovf %b",
                                     exp_w.word, exp_w.at, exp_w.last, exp_w.status,
                                     exp_w.ovf);
                    end
                end
            end
            pop <= !recv_stall && (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // long receiver hold so the request side backs up against full
    initial
    begin : receiver_hold
        wait (hold_armed);
        @(posedge clk);
        recv_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_stall <= 1'b0;
    end

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_capacity(CAP_MAX);
        @(negedge clk);
        pending_requests.push_back(make_req(OP_MOV_REG, ALU_ADD, 1'b1, '0, 0));
        pending_requests.push_back(make_req(OP_MOV_IMM, ALU_ADD, 1'b1, 64'h0, 0));
        pending_requests.push_back(make_req(OP_MOV_IMM, ALU_ADD, 1'b0, 64'h0, 0));
        pending_requests.push_back(make_req(OP_MOV_IMM, ALU_ADD, 1'b1, '1, 0));
        pending_requests.push_back(make_req(OP_MOV_IMM, ALU_ADD, 1'b0,
                                            64'hDEAD_BEEF_0000_8001, 0));
        pending_requests.push_back(make_req(OP_LDR, ALU_ADD, 1'b1, '0, 32760));
        pending_requests.push_back(make_req(OP_STR, ALU_ADD, 1'b0, '0, -256));
        pending_requests.push_back(make_req(OP_STR, ALU_ADD, 1'b1, '0, 4));
        pending_requests.push_back(make_req(OP_LDR, ALU_ADD, 1'b0, '0, -257));
        pending_requests.push_back(make_req(OP_LDP_PRE, ALU_ADD, 1'b1, '0, -512));
        pending_requests.push_back(make_req(OP_STP_POST, ALU_ADD, 1'b0, '0, 252));
        pending_requests.push_back(make_req(OP_LDP_POST, ALU_ADD, 1'b1, '0, 4));
        pending_requests.push_back(make_req(OP_STP_PRE, ALU_ADD, 1'b0, '0, 256));
        pending_requests.push_back(make_req(OP_ALU_REG, ALU_BIC, 1'b1, '0, 0));
        pending_requests.push_back(make_req(OP_ALU_REG, ALU_UNDEF_TOP, 1'b0, '0, 0));
        pending_requests.push_back(make_req(OP_ALU_IMM, ALU_ADD, 1'b1, 64'hFF_F000, 0));
        pending_requests.push_back(make_req(OP_ALU_IMM, ALU_SUB, 1'b0, 64'h0, 0));
        pending_requests.push_back(make_req(OP_ALU_IMM, ALU_ORR, 1'b1, 64'h10, 0));
        pending_requests.push_back(make_req(OP_ALU_IMM, ALU_ADD, 1'b0, 64'h1_0000_0000, 0));
        pending_requests.push_back(make_req(OP_CMP_REG, ALU_ADD, 1'b1, '0, 0));
        pending_requests.push_back(make_req(OP_CMP_IMM, ALU_ADD, 1'b0, 64'h100_0000, 0));
        for (int c = OP_B; c <= OP_RET; c++)
            pending_requests.push_back(make_req(5'(c), ALU_ADD, 1'(c), '0, 0));
        pending_requests.push_back(make_req(OP_UNDEF_TOP, ALU_ADD, 1'b0, '0, 0));
        wait_until_drained();

        // odd capacity a bit past the current offset: buffer fills mid-phase
        write_capacity(write_ptr + 24'd601);
        @(negedge clk);
        no_idle = 1'b1;
        queue_random(150);
        wait_until_drained();
        no_idle = 1'b0;

        write_capacity(CAP_NONE);
        @(negedge clk);
        hold_armed = 1'b1;
        queue_random(80);
        wait_until_drained();

        write_capacity(CAP_MAX);
        @(negedge clk);
        queue_random(170);
        wait_until_drained();

        $display("covered %0d requests, %0d words checked (%0d error, %0d dropped)",
                 requests_sent, words_checked, error_words, dropped_words);
        $display("over %0d capacity settings, an idle-free stretch and a %0d-cycle pop hold",
                 capacity_writes, HOLD_CYCLES);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/a64enc_pkg.sv
hdl/a64enc_front.sv
hdl/a64enc_queue.sv
hdl/a64enc_back.sv
hdl/a64_instruction_word_encoder_unit.sv
hdl/a64enc_checker.sv
tb/tb.sv
